// File: sv/fixed_block_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fixed block pool allocator: assertion macros
// Short forms for the concurrent checks on the top level, clocked on aclk
// and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define FBPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fbpa: check failed");

// Consequent must hold in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fbpa: check failed");

`endif

// File: sv/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: package
// Field widths, codes, payload structs and state encodings shared by the
// front end, the command queue and the free-list engine.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 17;
    localparam int CNT_W      = 11;
    localparam int IDXOUT_W   = 10;
    localparam int STAT_W     = 2;
    localparam int OFF_W      = 28;  // limit * size always fits here
    localparam int BIT_W      = 4;   // counts quotient bits 0 .. CNT_W-1
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int MGMT_FIXED = 12;
    localparam int MGMT_SHIFT = 3;   // 8 bytes of management per object
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(64);
    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] free_address;
    } fbpa_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [IDXOUT_W-1:0] object_index;
        logic [ADDR_W-1:0]   object_address;
        logic [CNT_W-1:0]    used_count;
    } fbpa_out_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_BAD
    } fbpa_op_t;

    typedef struct packed {
        fbpa_op_t         op;
        logic [OFF_W-1:0] offset;
    } fbpa_cmd_t;

    // Effective configuration, one register stage after the raw registers
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [OFF_W-1:0]  span;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  limit;
    } fbpa_cfg_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } fbpa_eng_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_DONE,
        ST_DIV,
        ST_FREE_WR,
        ST_RESULT
    } fbpa_state_t;

endpackage

// File: sv/fbpa_front.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: front end
// Holds the configuration registers, accepts requests and classifies them
// as allocate, free or bad address before handing them to the queue.
// ----------------------------------------------------------------------------
module fbpa_front #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fbpa_pkg::fbpa_in_t                 s_data,
    input  logic                               cfg_wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               clearing,
    output fbpa_pkg::fbpa_cfg_t                cfg,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output fbpa_pkg::fbpa_cmd_t                cmd
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_cfg_reg;
    logic [CNT_W-1:0]  limit_cfg_reg;
    fbpa_cfg_t         cfg_reg;
    fbpa_cfg_t         cfg_next;

    logic [SIZE_W-1:0] eff_size;
    logic [CNT_W-1:0]  eff_limit;

    logic              item_valid_reg;
    logic              item_valid_next;
    fbpa_in_t          item_reg;
    fbpa_in_t          item_next;

    logic [ADDR_W-1:0] offset;
    logic              bad_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            size_cfg_reg  <= SIZE_RESET;
            limit_cfg_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE:  base_reg      <= cfg_data[ADDR_W-1:0];
                CFG_SIZE:  size_cfg_reg  <= cfg_data[SIZE_W-1:0];
                CFG_LIMIT: limit_cfg_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero size counts as one byte; limit is capped at the pool depth
    always_comb begin
        eff_size  = (size_cfg_reg == '0) ? SIZE_W'(1) : size_cfg_reg;
        eff_limit = (32'(limit_cfg_reg) > 32'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                           : limit_cfg_reg;
        cfg_next.size  = eff_size;
        cfg_next.limit = eff_limit;
        cfg_next.span  = OFF_W'(eff_limit) * OFF_W'(eff_size);
        cfg_next.start = base_reg + ADDR_W'(MGMT_FIXED)
                       + (ADDR_W'(eff_limit) << MGMT_SHIFT);
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

    // Classify the held transaction
    always_comb begin
        offset   = item_reg.free_address - cfg_reg.start;
        bad_addr = (offset >= ADDR_W'(cfg_reg.span));
        if (item_reg.func == FUNC_ALLOC) begin
            cmd.op = OP_ALLOC;
        end else if (bad_addr) begin
            cmd.op = OP_BAD;
        end else begin
            cmd.op = OP_FREE;
        end
        cmd.offset = offset[OFF_W-1:0];
    end

    assign cmd_valid = item_valid_reg;
    assign s_ready   = !clearing && (!item_valid_reg || cmd_ready);

    always_comb begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (cmd_valid && cmd_ready) begin
            item_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            item_valid_next = 1'b1;
            item_next       = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

// File: sv/fbpa_queue.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: command queue
// Short FIFO of classified commands between the front end and the engine.
// ----------------------------------------------------------------------------
module fbpa_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbpa_pkg::fbpa_cmd_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fbpa_pkg::fbpa_cmd_t out_data
);
    import fbpa_pkg::*;

    localparam int QCNT_W = QPTR_W + 1;

    fbpa_cmd_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: sv/fbpa_engine.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: free-list engine
// Owns the next-free memory, head and use count. Pops for allocate, divides
// the offset by the object size one quotient bit a cycle for free, then
// pushes; results leave through an output register.
// ----------------------------------------------------------------------------
module fbpa_engine #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fbpa_pkg::fbpa_cfg_t      cfg,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  fbpa_pkg::fbpa_cmd_t      cmd,
    output logic                     m_valid,
    input  logic                     m_ready,
    output fbpa_pkg::fbpa_out_t      m_data,
    output fbpa_pkg::fbpa_eng_stat_t stat
);
    import fbpa_pkg::*;

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PTR_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    fbpa_state_t      state_reg;
    fbpa_state_t      state_next;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [PTR_W-1:0] clr_cnt_reg;
    logic [PTR_W-1:0] clr_cnt_next;
    logic [OFF_W-1:0] rem_reg;
    logic [OFF_W-1:0] rem_next;
    logic [CNT_W-1:0] quot_reg;
    logic [CNT_W-1:0] quot_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic [OFF_W-1:0] prod_reg;
    logic [OFF_W-1:0] prod_next;
    fbpa_out_t        res_reg;
    fbpa_out_t        res_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    fbpa_out_t        m_data_reg;
    fbpa_out_t        m_data_next;

    logic [PTR_W-1:0] next_free_mem [POOL_DEPTH];
    logic [PTR_W-1:0] rdata_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [PTR_W-1:0] wr_data;

    logic [OFF_W-1:0] divisor_sh;
    logic             sub_ok;

    function automatic fbpa_out_t make_res(
        input logic [STAT_W-1:0]   status,
        input logic [IDXOUT_W-1:0] index,
        input logic [ADDR_W-1:0]   address,
        input logic [CNT_W-1:0]    used
    );
        fbpa_out_t r;
        r.status         = status;
        r.object_index   = index;
        r.object_address = address;
        r.used_count     = used;
        return r;
    endfunction

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        clr_cnt_next = clr_cnt_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        bit_next     = bit_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cmd_ready    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = IDX_W'(head_reg);
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(quot_reg);
        wr_data      = head_reg;
        divisor_sh   = OFF_W'(cfg.size) << bit_reg;
        sub_ok       = (rem_reg >= divisor_sh);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // Rebuild the initial chain: entry i points at i + 1
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg[IDX_W-1:0];
                wr_data = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PTR_W'(POOL_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    unique case (cmd.op)
                        OP_ALLOC: begin
                            if (used_reg >= cfg.limit
                                || CMP_W'(head_reg) >= CMP_W'(cfg.limit)) begin
                                res_next   = make_res(STAT_FULL, '0, '0, used_reg);
                                state_next = ST_RESULT;
                            end else begin
                                rd_en      = 1'b1;
                                prod_next  = OFF_W'(CNT_W'(head_reg)) * OFF_W'(cfg.size);
                                state_next = ST_ALLOC_DONE;
                            end
                        end
                        OP_FREE: begin
                            if (used_reg == '0) begin
                                res_next   = make_res(STAT_EMPTY, '0, '0, used_reg);
                                state_next = ST_RESULT;
                            end else begin
                                rem_next   = cmd.offset;
                                quot_next  = '0;
                                bit_next   = BIT_W'(CNT_W - 1);
                                state_next = ST_DIV;
                            end
                        end
                        OP_BAD: begin
                            res_next   = make_res(STAT_BAD, '0, '0, used_reg);
                            state_next = ST_RESULT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ALLOC_DONE: begin
                head_next  = rdata_reg;
                used_next  = used_reg + 1'b1;
                res_next   = make_res(STAT_OK, IDXOUT_W'(head_reg),
                                      cfg.start + ADDR_W'(prod_reg), used_reg + 1'b1);
                state_next = ST_RESULT;
            end
            ST_DIV: begin
                // Restoring division, most significant quotient bit first
                if (sub_ok) begin
                    rem_next = rem_reg - divisor_sh;
                end
                quot_next = {quot_reg[CNT_W-2:0], sub_ok};
                if (bit_reg == '0) begin
                    state_next = ST_FREE_WR;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_FREE_WR: begin
                wr_en      = 1'b1;
                head_next  = PTR_W'(quot_reg);
                used_next  = used_reg - 1'b1;
                res_next   = make_res(STAT_OK, IDXOUT_W'(quot_reg), '0, used_reg - 1'b1);
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            head_reg    <= '0;
            used_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            used_reg    <= used_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        bit_reg    <= bit_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            next_free_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= next_free_mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.busy     = (state_reg != ST_IDLE);

endmodule

// File: sv/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator: top level
// Index-linked free list over POOL_DEPTH fixed-size objects: allocate pops
// an index and returns its byte address, free maps an address back to an
// index and pushes it.
// ----------------------------------------------------------------------------
// After reset the block rebuilds the free list in its next-free memory and
// holds s_ready low meanwhile; configuration writes are taken at any time.
// One request is worked at a time by the engine, while the front end and a
// two-entry queue keep taking requests. An allocate reads the list head
// from memory, forms the byte address and gives the result; a free runs a
// restoring division by the object size, one quotient bit a cycle, then
// the list push; full, empty or bad-address requests go straight to the
// result. The divider sets the rate for frees; the registered read of the
// next-free memory sets it for allocates.
module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fbpa_pkg::fbpa_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fbpa_pkg::fbpa_out_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbpa_pkg::*;

`include "fixed_block_pool_allocator_defines.svh"

    fbpa_cfg_t      cfg_view;
    fbpa_eng_stat_t eng_stat;
    logic           fq_valid;
    logic           fq_ready;
    fbpa_cmd_t      fq_cmd;
    logic           qe_valid;
    logic           qe_ready;
    fbpa_cmd_t      qe_cmd;
    logic           fail_reply;

    fbpa_front #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (eng_stat.clearing),
        .cfg       (cfg_view),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    fbpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_cmd),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_data  (qe_cmd)
    );

    fbpa_engine #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_view),
        .cmd_valid (qe_valid),
        .cmd_ready (qe_ready),
        .cmd       (qe_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .stat      (eng_stat)
    );

    assign fail_reply = m_valid && (m_data.status != STAT_OK);

    // No transaction may enter while the free list is being rebuilt
    `FBPA_ASSERT_NOW(a_no_accept_clear, eng_stat.clearing, !s_ready)
    // Failed requests carry neither index nor address
    `FBPA_ASSERT_NOW(a_fail_zero, fail_reply, {m_data.object_index, m_data.object_address} == '0)
    // Use count never passes the pool depth
    `FBPA_ASSERT_NOW(a_used_bound, m_valid, 32'(m_data.used_count) <= POOL_DEPTH)
    // A new result only follows engine work
    `FBPA_ASSERT_NOW(a_result_src, $rose(m_valid), $past(eng_stat.busy))
    // The rebuild runs once per reset
    `FBPA_ASSERT_NEXT(a_clear_once, !eng_stat.clearing, !eng_stat.clearing)

endmodule

// File: bench/fixed_block_pool_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator: self-checking testbench
// Drives allocate and free requests through the valid/ready ports, with
// random idle cycles on both sides. A free-list model inside the bench
// predicts every reply, and each reply is compared field by field. The run
// starts with a short directed script that covers reset state, extremes and
// error codes, then steps through a series of pool layouts with random
// traffic that alternates between filling and draining the pool.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int POOL_DEPTH    = 1024;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 155;
    localparam int SETTLE_CYCLES = 40;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic                     func;
        logic [ADDR_W-1:0]        addr;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        bit                       typed;
        fbpa_out_t                reply;
    } step_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    fbpa_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    fbpa_out_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Free-list model state and its copy of the registers
    logic [CNT_W-1:0]  pool_next [0:POOL_DEPTH-1];
    logic [CNT_W-1:0]  pool_head;
    logic [CNT_W-1:0]  pool_used;
    logic [ADDR_W-1:0] cfg_base;
    logic [SIZE_W-1:0] cfg_size;
    logic [CNT_W-1:0]  cfg_limit;

    fbpa_out_t         pool_replies [$];
    logic [ADDR_W-1:0] live_objects [$];
    step_row_t         directed_rows [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int rx_hold        = 0;
    bit no_gaps        = 1'b0;
    fbpa_out_t want_reply;

    fixed_block_pool_allocator #(.POOL_DEPTH(POOL_DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic fbpa_out_t make_reply(input logic [STAT_W-1:0] status,
                                             input int idx,
                                             input logic [ADDR_W-1:0] addr,
                                             input int used);
        fbpa_out_t r;
        r.status         = status;
        r.object_index   = IDXOUT_W'(idx);
        r.object_address = addr;
        r.used_count     = CNT_W'(used);
        return r;
    endfunction

    function automatic int pool_limit_eff();
        return (cfg_limit > CNT_W'(POOL_DEPTH)) ? POOL_DEPTH : int'(cfg_limit);
    endfunction

    function automatic logic [ADDR_W-1:0] pool_obj_size();
        return (cfg_size == '0) ? ADDR_W'(1) : ADDR_W'(cfg_size);
    endfunction

    function automatic logic [ADDR_W-1:0] pool_start();
        return cfg_base + ADDR_W'(MGMT_FIXED + 8 * pool_limit_eff());
    endfunction

    function automatic logic [ADDR_W-1:0] pool_span();
        return ADDR_W'(pool_limit_eff()) * pool_obj_size();
    endfunction

    // Work out the reply to one request and advance the free list
    function automatic fbpa_out_t predict_pool_reply(input fbpa_in_t req);
        fbpa_out_t         r;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] idx;
        r = '0;
        if (req.func == FUNC_ALLOC) begin
            if (pool_used >= pool_limit_eff() || pool_head >= pool_limit_eff()) begin
                r.status = STAT_FULL;
            end else begin
                idx              = ADDR_W'(pool_head);
                r.status         = STAT_OK;
                r.object_index   = idx[IDXOUT_W-1:0];
                r.object_address = pool_start() + idx * pool_obj_size();
                pool_head        = pool_next[idx[IDXOUT_W-1:0]];
                pool_used        = pool_used + 1'b1;
            end
        end else begin
            off = req.free_address - pool_start();
            if (off >= pool_span()) begin
                r.status = STAT_BAD;
            end else if (pool_used == '0) begin
                r.status = STAT_EMPTY;
            end else begin
                idx                               = off / pool_obj_size();
                r.status                          = STAT_OK;
                r.object_index                    = idx[IDXOUT_W-1:0];
                pool_next[idx[IDXOUT_W-1:0]]      = pool_head;
                pool_head                         = CNT_W'(idx);
                pool_used                         = pool_used - 1'b1;
            end
        end
        r.used_count = pool_used;
        return r;
    endfunction

    function automatic void add_req(input logic func, input logic [ADDR_W-1:0] addr,
                                    input bit typed, input fbpa_out_t reply);
        step_row_t row;
        row.kind    = ROW_REQ;
        row.func    = func;
        row.addr    = addr;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.typed   = typed;
        row.reply   = reply;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        step_row_t row;
        row.kind    = ROW_CFG;
        row.func    = FUNC_ALLOC;
        row.addr    = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed   = 1'b0;
        row.reply   = '0;
        directed_rows.push_back(row);
    endfunction

    // Present one request, hold it until taken, then record its reply
    task automatic send_request(input logic func, input logic [ADDR_W-1:0] addr,
                                input bit typed, input fbpa_out_t typed_reply);
        int        gap;
        fbpa_in_t  req;
        fbpa_out_t predicted;
        gap              = no_gaps ? 0 : $urandom_range(0, 8);
        req.func         = func;
        req.free_address = addr;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_pool_reply(req);
        pool_replies.push_back(typed ? typed_reply : predicted);
        if (func == FUNC_ALLOC && predicted.status == STAT_OK)
            live_objects.push_back(predicted.object_address);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pool_replies.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_BASE:  cfg_base  = val[ADDR_W-1:0];
            CFG_SIZE:  cfg_size  = val[SIZE_W-1:0];
            CFG_LIMIT: cfg_limit = val[CNT_W-1:0];
            default: ;
        endcase
        // addresses handed out under the old layout no longer mean anything
        live_objects.delete();
    endtask

    // Reply checker with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pool_replies.size() == 0) begin
                    report_mismatch("reply with no request outstanding");
                end else begin
                    want_reply = pool_replies.pop_front();
                    if (m_data.status !== want_reply.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                        m_data.status, want_reply.status));
                    if (m_data.object_index !== want_reply.object_index)
                        report_mismatch($sformatf("object_index got %0d want %0d",
                                        m_data.object_index, want_reply.object_index));
                    if (m_data.object_address !== want_reply.object_address)
                        report_mismatch($sformatf("object_address got %0h want %0h",
                                        m_data.object_address,
                                        want_reply.object_address));
                    if (m_data.used_count !== want_reply.used_count)
                        report_mismatch($sformatf("used_count got %0d want %0d",
                                        m_data.used_count, want_reply.used_count));
                end
                rx_hold = no_gaps ? 0 : $urandom_range(0, 8);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    initial begin : stimulus
        int                p;
        int                n;
        int                k;
        int                pick;
        bit                filling;
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  limit;

        for (int i = 0; i < POOL_DEPTH; i++)
            pool_next[i] = CNT_W'(i + 1);
        pool_head = '0;
        pool_used = '0;
        cfg_base  = '0;
        cfg_size  = SIZE_RESET;
        cfg_limit = LIMIT_RESET;

        // Reset layout: data region starts at 12 + 8*1024 = 8204, 64 bytes each
        add_req(FUNC_FREE, 48'd8204, 1'b1, make_reply(STAT_EMPTY, 0, '0, 0));
        add_req(FUNC_FREE, 48'd0, 1'b1, make_reply(STAT_BAD, 0, '0, 0));
        add_req(FUNC_FREE, 48'hFFFF_FFFF_FFFF, 1'b1, make_reply(STAT_BAD, 0, '0, 0));
        add_req(FUNC_ALLOC, 48'hFFFF_FFFF_FFFF, 1'b1, make_reply(STAT_OK, 0, 48'd8204, 1));
        add_req(FUNC_ALLOC, 48'd0, 1'b1, make_reply(STAT_OK, 1, 48'd8268, 2));
        // one past the last object, then the last byte of the last object
        add_req(FUNC_FREE, 48'd73740, 1'b1, make_reply(STAT_BAD, 0, '0, 2));
        add_req(FUNC_FREE, 48'd73739, 1'b1, make_reply(STAT_OK, 1023, '0, 1));
        add_req(FUNC_ALLOC, 48'd0, 1'b1, make_reply(STAT_OK, 1023, 48'd73676, 2));
        // mid-object address truncates to the object's index
        add_req(FUNC_FREE, 48'd8331, 1'b1, make_reply(STAT_OK, 1, '0, 1));
        add_req(FUNC_FREE, 48'd8204, 1'b1, make_reply(STAT_OK, 0, '0, 0));
        add_req(FUNC_FREE, 48'd8204, 1'b1, make_reply(STAT_EMPTY, 0, '0, 0));
        // Zero size acts as one byte, limit above depth acts as depth; start wraps
        add_cfg(CFG_BASE, 48'hFFFF_FFFF_FFF0);
        add_cfg(CFG_SIZE, 48'd0);
        add_cfg(CFG_LIMIT, 48'd2047);
        add_req(FUNC_ALLOC, 48'd0, 1'b1, make_reply(STAT_OK, 0, 48'd8188, 1));
        add_req(FUNC_ALLOC, 48'd0, 1'b1, make_reply(STAT_OK, 1, 48'd8189, 2));
        add_req(FUNC_FREE, 48'd9211, 1'b0, '0);
        add_req(FUNC_FREE, 48'd9212, 1'b0, '0);
        add_req(FUNC_FREE, 48'hFFFF_FFFF_FFFF, 1'b0, '0);
        // Single object of 65536 bytes, base at the top of the space
        add_cfg(CFG_BASE, 48'hFFFF_FFFF_FFFF);
        add_cfg(CFG_SIZE, 48'd65536);
        add_cfg(CFG_LIMIT, 48'd1);
        add_req(FUNC_ALLOC, 48'd0, 1'b0, '0);
        add_req(FUNC_FREE, 48'd65554, 1'b0, '0);
        add_req(FUNC_ALLOC, 48'd0, 1'b0, '0);
        add_req(FUNC_ALLOC, 48'd0, 1'b0, '0);
        add_req(FUNC_FREE, 48'd65555, 1'b0, '0);
        add_req(FUNC_FREE, 48'd18, 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_request(directed_rows[i].func, directed_rows[i].addr,
                             directed_rows[i].typed, directed_rows[i].reply);
            end
        end

        filling = 1'b1;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin base = '0;               size = 17'd1;     limit = 11'd1;    end
                1: begin base = 48'hFFFF_FFFF_FFFF; size = 17'd65536; limit = 11'd1024; end
                2: begin base = rand48();         size = '0;        limit = 11'd2047; end
                default: begin
                    case ($urandom_range(0, 3))
                        0: base = '0;
                        1: base = rand48();
                        2: base = 48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 20000));
                        default: base = ADDR_W'($urandom_range(0, 1 << 20));
                    endcase
                    case ($urandom_range(0, 3))
                        0: size = SIZE_W'($urandom_range(1, 16));
                        1: size = SIZE_W'($urandom_range(1, 65536));
                        2: size = SIZE_W'(1 << $urandom_range(0, 16));
                        default: size = SIZE_W'($urandom_range(60, 70));
                    endcase
                    case ($urandom_range(0, 3))
                        0: limit = CNT_W'($urandom_range(1, 8));
                        1: limit = CNT_W'($urandom_range(1, 64));
                        2: limit = CNT_W'($urandom_range(1, 1024));
                        default: limit = CNT_W'($urandom_range(1, 2047));
                    endcase
                end
            endcase
            wait_drained();
            no_gaps = (p % 4 == 3);
            write_register(CFG_BASE, base);
            write_register(CFG_SIZE, CFG_DATA_W'(size));
            write_register(CFG_LIMIT, CFG_DATA_W'(limit));

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // swing between filling and draining the pool
                if ($urandom_range(0, 29) == 0)
                    filling = !filling;
                pick = $urandom_range(0, 99);
                addr = rand48();
                if (pick < 8) begin
                    func = 1'($urandom_range(0, 1));
                end else if (pick < (filling ? 78 : 30)) begin
                    func = FUNC_ALLOC;
                end else begin
                    func = FUNC_FREE;
                    pick = $urandom_range(0, 9);
                    if (live_objects.size() != 0 && pick < 6) begin
                        k    = $urandom_range(0, live_objects.size() - 1);
                        addr = live_objects[k]
                             + ADDR_W'($urandom_range(0, int'(pool_obj_size()) - 1));
                        live_objects.delete(k);
                    end else if (pick < 8) begin
                        addr = pool_start() + (ADDR_W'($urandom) % pool_span());
                    end else begin
                        case ($urandom_range(0, 3))
                            0: addr = pool_start() - 1'b1;
                            1: addr = pool_start();
                            2: addr = pool_start() + pool_span() - 1'b1;
                            default: addr = pool_start() + pool_span();
                        endcase
                    end
                end
                send_request(func, addr, 1'b0, '0);
                // now and then let every reply come home before going on
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
